@@ hdl/tlbpt_pkg.sv @@
// Shared field widths for the TLB page translation block.
`default_nettype none
package tlbpt_pkg;
  localparam int LA_W    = 20;  // logical address field
  localparam int PA_W    = 18;  // physical address field
  localparam int FN_W    = 8;   // frame number field
  localparam int EP_W    = 10;  // evicted page field
  localparam int STAMP_W = 32;  // use stamp and access clock
endpackage
`default_nettype wire

@@ hdl/tlb_page_translate_fifo_lru.sv @@
// Demand-paging translator: FIFO-filled TLB, page table, FIFO or LRU replacement.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------
//  in      | in_logical_address                      | in_valid / in_stall
//  out     | out_phys_addr .. out_evicted_page       | out_valid / out_stall
//  cfg     | cfg_wr_data (replacement policy)        | cfg_wr_en
//
// A TLB hit and a TLB miss on a mapped page finish from ST_LOOK. A fault with free
// frames goes to ST_FILL; FIFO eviction reads the owner of the next frame first; LRU
// eviction runs a stamp scan over all pages through the single page-table read port.
// After reset a clearing pass wipes every page-table entry; in_stall stays high meanwhile.
// One item is worked at a time; the result waits in an output register while the
// next item is taken.
`default_nettype none
module tlb_page_translate_fifo_lru #(
  parameter int TLB_ENTRIES     = 16,
  parameter int LOGICAL_PAGES   = 1024,
  parameter int PHYSICAL_FRAMES = 256,
  parameter int OFFSET_WIDTH    = 10
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [tlbpt_pkg::LA_W-1:0]     in_logical_address,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [tlbpt_pkg::PA_W-1:0]     out_phys_addr,
  output logic [tlbpt_pkg::FN_W-1:0]     out_frame_number,
  output logic                           out_tlb_hit,
  output logic                           out_page_fault,
  output logic                           out_evicted,
  output logic [tlbpt_pkg::EP_W-1:0]     out_evicted_page,
  input  wire                            cfg_wr_en,
  input  wire                            cfg_wr_data
);
  import tlbpt_pkg::*;

  localparam int PW   = $clog2(LOGICAL_PAGES);
  localparam int FW   = (PHYSICAL_FRAMES > 2) ? $clog2(PHYSICAL_FRAMES) : 1;
  localparam int TW   = (TLB_ENTRIES > 2) ? $clog2(TLB_ENTRIES) : 1;
  localparam int PT_W = 1 + FW + STAMP_W;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_OWN, ST_VICT, ST_SCAN, ST_EVICT, ST_FILL, ST_DONE
  } state_t;

  state_t              state_r;
  logic                policy_r;
  logic [PW-1:0]       page_r;
  logic [OFFSET_WIDTH-1:0] offset_r;
  logic [FW-1:0]       frame_r;
  logic                hit_r, fault_r, evict_r;
  logic [PW-1:0]       victim_r;
  logic [FW-1:0]       nff_r;
  logic                full_r;
  logic [STAMP_W-1:0]  clock_r;
  logic [PW-1:0]       clr_r;
  logic [TW-1:0]       fill_ptr_r;
  logic                tlb_valid_r [TLB_ENTRIES];
  logic [PW-1:0]       tlb_page_r  [TLB_ENTRIES];
  logic [FW-1:0]       tlb_frame_r [TLB_ENTRIES];
  logic [PW:0]         scan_addr_r;
  logic                scan_dv_r;
  logic [PW-1:0]       scan_lag_r;
  logic                found_r;
  logic [PW-1:0]       best_page_r;
  logic [FW-1:0]       best_frame_r;
  logic [STAMP_W-1:0]  best_stamp_r;
  logic                out_valid_r;
  logic [PA_W-1:0]     out_pa_r;
  logic [FN_W-1:0]     out_fn_r;
  logic                out_hit_r, out_fault_r, out_evict_r;
  logic [EP_W-1:0]     out_ep_r;

  // page table memory: {valid, frame, stamp}; frame owner memory
  logic [PT_W-1:0]     pt_mem [LOGICAL_PAGES];
  logic [PT_W-1:0]     pt_rd_r;
  logic [PW-1:0]       owner_mem [PHYSICAL_FRAMES];
  logic [PW-1:0]       owner_rd_r;

  logic [LA_W+PW-1:0]  in_ext;
  logic [PW-1:0]       in_page;
  logic [PW-1:0]       pt_raddr;
  logic                pt_we;
  logic [PW-1:0]       pt_waddr;
  logic [PT_W-1:0]     pt_wdata;
  logic                pt_rd_valid;
  logic [FW-1:0]       pt_rd_frame;
  logic [STAMP_W-1:0]  pt_rd_stamp;
  logic                tlb_hit_c;
  logic [FW-1:0]       tlb_hit_frame;
  logic                refill_c;
  logic [FW-1:0]       refill_frame;
  logic                take_c;
  logic                found_nxt;
  logic [PW-1:0]       best_page_nxt;
  logic [FW-1:0]       best_frame_nxt;
  logic                scan_last;
  logic                out_free;
  logic [FW-1:0]       nff_nxt;

  // split the address
  assign in_ext  = {{PW{1'b0}}, in_logical_address} >> OFFSET_WIDTH;
  assign in_page = in_ext[PW-1:0];

  assign pt_rd_valid = pt_rd_r[PT_W-1];
  assign pt_rd_frame = pt_rd_r[STAMP_W +: FW];
  assign pt_rd_stamp = pt_rd_r[STAMP_W-1:0];

  // search the TLB; the lowest matching entry wins
  always_comb begin
    tlb_hit_c     = 1'b0;
    tlb_hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_r[i] && tlb_page_r[i] == page_r) begin
        tlb_hit_c     = 1'b1;
        tlb_hit_frame = tlb_frame_r[i];
      end
    end
  end

  // refill on every miss that resolves here
  assign refill_c     = (state_r == ST_FILL) ||
                        (state_r == ST_LOOK && !tlb_hit_c && pt_rd_valid);
  assign refill_frame = (state_r == ST_FILL) ? frame_r : pt_rd_frame;

  // page table read address
  always_comb begin
    unique case (state_r)
      ST_IDLE: pt_raddr = in_page;
      ST_OWN:  pt_raddr = owner_rd_r;
      ST_SCAN: pt_raddr = scan_addr_r[PW-1:0];
      default: pt_raddr = page_r;
    endcase
  end

  // page table write port
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = page_r;
    pt_wdata = {1'b1, refill_frame, clock_r};
    if (state_r == ST_CLEAR) begin
      pt_we    = 1'b1;
      pt_waddr = clr_r;
      pt_wdata = '0;
    end else if (state_r == ST_EVICT) begin
      pt_we    = evict_r;
      pt_waddr = victim_r;
      pt_wdata = '0;
    end else if (refill_c) begin
      pt_we    = 1'b1;
    end
  end

  // LRU scan compare, strict less keeps the lowest page on ties
  assign take_c = scan_dv_r && pt_rd_valid && (!found_r || pt_rd_stamp < best_stamp_r);
  assign found_nxt      = found_r || take_c;
  assign best_page_nxt  = take_c ? scan_lag_r : best_page_r;
  assign best_frame_nxt = take_c ? pt_rd_frame : best_frame_r;
  assign scan_last      = scan_dv_r && (scan_lag_r == PW'(LOGICAL_PAGES - 1));

  assign nff_nxt  = (nff_r == FW'(PHYSICAL_FRAMES - 1)) ? '0 : nff_r + 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  // memories
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rd_r <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FILL) begin
      owner_mem[frame_r] <= page_r;
    end
    owner_rd_r <= owner_mem[nff_r];
  end

  // sequencer, TLB and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      policy_r    <= 1'b0;
      clr_r       <= '0;
      fill_ptr_r  <= '0;
      nff_r       <= '0;
      full_r      <= 1'b0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
      scan_dv_r   <= 1'b0;
      found_r     <= 1'b0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_valid_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        policy_r <= cfg_wr_data;
      end
      // drop a taken result unless a new one replaces it
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end

      // refill TLB, stamp page, advance clock
      if (refill_c) begin
        tlb_valid_r[fill_ptr_r] <= 1'b1;
        tlb_page_r[fill_ptr_r]  <= page_r;
        tlb_frame_r[fill_ptr_r] <= refill_frame;
        fill_ptr_r <= (fill_ptr_r == TW'(TLB_ENTRIES - 1)) ? '0 : fill_ptr_r + 1'b1;
        clock_r    <= clock_r + 1'b1;
      end

      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == PW'(LOGICAL_PAGES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            page_r   <= in_page;
            offset_r <= in_logical_address[OFFSET_WIDTH-1:0];
            hit_r    <= 1'b0;
            fault_r  <= 1'b0;
            evict_r  <= 1'b0;
            state_r  <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          priority if (tlb_hit_c) begin
            hit_r   <= 1'b1;
            frame_r <= tlb_hit_frame;
            state_r <= ST_DONE;
          end else if (pt_rd_valid) begin
            frame_r <= pt_rd_frame;
            state_r <= ST_DONE;
          end else begin
            fault_r <= 1'b1;
            frame_r <= nff_r;
            if (!full_r) begin
              state_r <= ST_FILL;
            end else if (policy_r) begin
              scan_addr_r <= '0;
              scan_dv_r   <= 1'b0;
              found_r     <= 1'b0;
              state_r     <= ST_SCAN;
            end else begin
              state_r <= ST_OWN;
            end
          end
        end
        ST_OWN: begin
          state_r <= ST_VICT;
        end
        ST_VICT: begin
          victim_r <= owner_rd_r;
          evict_r  <= pt_rd_valid && (pt_rd_frame == nff_r);
          state_r  <= ST_EVICT;
        end
        ST_SCAN: begin
          scan_dv_r    <= !scan_last && (scan_addr_r < (PW+1)'(LOGICAL_PAGES));
          scan_lag_r   <= scan_addr_r[PW-1:0];
          scan_addr_r  <= scan_addr_r + 1'b1;
          found_r      <= found_nxt;
          best_page_r  <= best_page_nxt;
          best_frame_r <= best_frame_nxt;
          if (take_c) begin
            best_stamp_r <= pt_rd_stamp;
          end
          if (scan_last) begin
            victim_r  <= best_page_nxt;
            evict_r   <= found_nxt;
            frame_r   <= found_nxt ? best_frame_nxt : nff_r;
            state_r   <= ST_EVICT;
          end
        end
        ST_EVICT: begin
          // drop every TLB entry of the victim page
          if (evict_r) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
              if (tlb_page_r[i] == victim_r) begin
                tlb_valid_r[i] <= 1'b0;
              end
            end
          end
          state_r <= ST_FILL;
        end
        ST_FILL: begin
          nff_r <= nff_nxt;
          if (nff_nxt == '0) begin
            full_r <= 1'b1;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pa_r    <= PA_W'({frame_r, offset_r});
            out_fn_r    <= FN_W'(frame_r);
            out_hit_r   <= hit_r;
            out_fault_r <= fault_r;
            out_evict_r <= evict_r;
            out_ep_r    <= evict_r ? EP_W'(victim_r) : '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_phys_addr        = out_pa_r;
  assign out_frame_number     = out_fn_r;
  assign out_tlb_hit          = out_hit_r;
  assign out_page_fault       = out_fault_r;
  assign out_evicted          = out_evict_r;
  assign out_evicted_page     = out_ep_r;

  // a result only appears after the sequencer finishes an item
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside finish state");

  // an eviction only happens on a fault
  a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evict_r |-> out_fault_r && !out_hit_r)
    else $error("eviction without page fault");

  // a hit never faults
  a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_fault_r))
    else $error("hit and fault together");

  // once all frames are used they stay used
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("frames full flag dropped");

endmodule
`default_nettype wire
